FILE: rtl/spm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stream pattern matcher.
// No dependencies; compile first.
package spm_pkg;

	localparam int REQ_BITS       = 2;
	localparam int BYTE_BITS      = 8;
	localparam int INDEX_BITS     = 6;
	localparam int LEN_BITS       = 7;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 7;

	localparam logic [REQ_BITS-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_STREAM = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_START  = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_AT_FIRST  = 1'd1;

	localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd1;

	typedef struct packed {
		logic [REQ_BITS-1:0]   req_type;
		logic [BYTE_BITS-1:0]  byte_value;
		logic [INDEX_BITS-1:0] pattern_index;
	} item_t;

endpackage

FILE: rtl/spm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and match results.
// Depends on spm_pkg.
interface spm_req_if;
	logic                             valid;
	logic                             ready;
	logic [spm_pkg::REQ_BITS-1:0]     req_type;
	logic [spm_pkg::BYTE_BITS-1:0]    byte_value;
	logic [spm_pkg::INDEX_BITS-1:0]   pattern_index;

	modport source (output valid, output req_type, output byte_value,
		output pattern_index, input ready);
	modport sink (input valid, input req_type, input byte_value,
		input pattern_index, output ready);
endinterface

interface spm_res_if #(parameter int OFFSET_BITS = 40);
	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] match_offset;
	logic                   first_mode_stop;

	modport source (output valid, output match_offset, output first_mode_stop,
		input ready);
	modport sink (input valid, input match_offset, input first_mode_stop,
		output ready);
endinterface

FILE: rtl/spm_stream.sv
`timescale 1ns / 1ps
// Stream state: pattern store, byte window, fill count, position, stop flag.
// Depends on spm_pkg.
module spm_stream #(
	parameter int PATTERN_MAX = 64,
	parameter int OFFSET_BITS = 40,
	parameter int FILL_BITS   = $clog2(PATTERN_MAX + 1)
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       fire,
	input  spm_pkg::item_t                             item,
	input  logic                                       stop_set,
	output logic [PATTERN_MAX*spm_pkg::BYTE_BITS-1:0]  window_nx,
	output logic [PATTERN_MAX*spm_pkg::BYTE_BITS-1:0]  pattern_flat,
	output logic [FILL_BITS-1:0]                       fill_nx,
	output logic [OFFSET_BITS-1:0]                     pos,
	output logic                                       stream_en
);
	import spm_pkg::*;

	localparam int WB = PATTERN_MAX * BYTE_BITS;

	logic [WB-1:0]          window_q;
	logic [BYTE_BITS-1:0]   pattern_q [PATTERN_MAX];
	logic [FILL_BITS-1:0]   fill_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   stopped_q;
	logic                   load_en;
	logic                   start_en;
	logic                   shift_en;

	assign load_en   = fire && (item.req_type == REQ_LOAD);
	assign start_en  = fire && (item.req_type == REQ_START);
	assign stream_en = (item.req_type == REQ_STREAM) && !stopped_q;
	assign shift_en  = fire && stream_en;
	assign pos       = pos_q;

	generate
		if (PATTERN_MAX > 1) begin : g_win
			assign window_nx = {window_q[WB-BYTE_BITS-1:0], item.byte_value};
		end else begin : g_win1
			assign window_nx = item.byte_value;
		end
	endgenerate

	assign fill_nx = (fill_q == FILL_BITS'(PATTERN_MAX)) ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			window_q <= window_nx;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (load_en && (int'(item.pattern_index) == i)) begin
				pattern_q[i] <= item.byte_value;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < PATTERN_MAX; g++) begin : g_pat
			assign pattern_flat[g*BYTE_BITS +: BYTE_BITS] = pattern_q[g];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pos_q     <= '0;
			stopped_q <= 1'b0;
		end else if (start_en) begin
			fill_q    <= '0;
			pos_q     <= '0;
			stopped_q <= 1'b0;
		end else if (shift_en) begin
			fill_q <= fill_nx;
			pos_q  <= pos_q + 1'b1;
			if (stop_set) begin
				stopped_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/spm_cmp.sv
`timescale 1ns / 1ps
// Window compare: aligns the newest bytes to the pattern and checks them all at once.
// Depends on spm_pkg.
module spm_cmp #(
	parameter int PATTERN_MAX = 64,
	parameter int OFFSET_BITS = 40,
	parameter int FILL_BITS   = $clog2(PATTERN_MAX + 1)
) (
	input  logic [PATTERN_MAX*spm_pkg::BYTE_BITS-1:0] window_nx,
	input  logic [PATTERN_MAX*spm_pkg::BYTE_BITS-1:0] pattern_flat,
	input  logic [spm_pkg::LEN_BITS-1:0]              len,
	input  logic [FILL_BITS-1:0]                      fill_nx,
	input  logic [OFFSET_BITS-1:0]                    pos,
	output logic                                      hit,
	output logic [OFFSET_BITS-1:0]                    offset
);
	import spm_pkg::*;

	localparam int WB = PATTERN_MAX * BYTE_BITS;

	logic [FILL_BITS-1:0] len_eff;
	logic [FILL_BITS-1:0] shamt;
	logic [WB-1:0]        rev;
	logic [WB-1:0]        aligned;
	logic [PATTERN_MAX-1:0] ok;

	assign len_eff = (int'(len) > PATTERN_MAX) ? FILL_BITS'(PATTERN_MAX) : FILL_BITS'(len);
	assign shamt   = FILL_BITS'(PATTERN_MAX) - len_eff;

	genvar g;
	generate
		for (g = 0; g < PATTERN_MAX; g++) begin : g_rev
			assign rev[g*BYTE_BITS +: BYTE_BITS] =
				window_nx[(PATTERN_MAX-1-g)*BYTE_BITS +: BYTE_BITS];
			assign ok[g] = (FILL_BITS'(g) >= len_eff) ||
				(aligned[g*BYTE_BITS +: BYTE_BITS] == pattern_flat[g*BYTE_BITS +: BYTE_BITS]);
		end
	endgenerate

	assign aligned = rev >> {shamt, 3'b000};
	assign hit     = (len_eff != '0) && (fill_nx >= len_eff) && (&ok);
	assign offset  = pos - (OFFSET_BITS'(len_eff) - 1'b1);

endmodule

FILE: rtl/stream_pattern_matcher_top.sv
`timescale 1ns / 1ps
// Stream pattern matcher top: input register, window state, compare, result register.
// Path: a stream byte is captured in the input register; its match result is captured in the result register.
// Throughput: one item per cycle unless the result register is stalled; the
// full-window compare sits between the input register and the result register.
// Reset: asynchronous, active low; clears position, fill, stop flag, valid flags; sets configuration to reset values.
module stream_pattern_matcher_top #(
	parameter int PATTERN_MAX = 64,
	parameter int OFFSET_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	spm_req_if.sink                             req,
	spm_res_if.source                           res,
	input  logic                                cfg_we,
	input  logic [spm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [spm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import spm_pkg::*;

	localparam int FILL_BITS = $clog2(PATTERN_MAX + 1);
	localparam int WB        = PATTERN_MAX * BYTE_BITS;

	logic [LEN_BITS-1:0]    len_q;
	logic                   stop_first_q;
	logic                   valid_s1;
	item_t                  item_s1;
	logic                   advance;
	logic                   fire;
	logic [WB-1:0]          window_nx;
	logic [WB-1:0]          pattern_flat;
	logic [FILL_BITS-1:0]   fill_nx;
	logic [OFFSET_BITS-1:0] pos;
	logic                   stream_en;
	logic                   hit;
	logic [OFFSET_BITS-1:0] offset;
	logic                   res_valid_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_RESET;
			stop_first_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PATTERN_LENGTH) begin
				len_q <= cfg_wdata[LEN_BITS-1:0];
			end
			if (cfg_index == CFG_STOP_AT_FIRST) begin
				stop_first_q <= cfg_wdata[0];
			end
		end
	end

	assign advance   = !res_valid_q || res.ready;
	assign req.ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type: req.req_type, byte_value: req.byte_value,
				pattern_index: req.pattern_index};
		end
	end

	spm_stream #(
		.PATTERN_MAX(PATTERN_MAX),
		.OFFSET_BITS(OFFSET_BITS),
		.FILL_BITS  (FILL_BITS)
	) u_stream (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.stop_set    (hit && stop_first_q),
		.window_nx   (window_nx),
		.pattern_flat(pattern_flat),
		.fill_nx     (fill_nx),
		.pos         (pos),
		.stream_en   (stream_en)
	);

	spm_cmp #(
		.PATTERN_MAX(PATTERN_MAX),
		.OFFSET_BITS(OFFSET_BITS),
		.FILL_BITS  (FILL_BITS)
	) u_cmp (
		.window_nx   (window_nx),
		.pattern_flat(pattern_flat),
		.len         (len_q),
		.fill_nx     (fill_nx),
		.pos         (pos),
		.hit         (hit),
		.offset      (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && stream_en && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && stream_en && hit) begin
			offset_q <= offset;
			stop_q   <= stop_first_q;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.match_offset    = offset_q;
	assign res.first_mode_stop = stop_q;

endmodule

FILE: rtl/spm_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the stream pattern matcher, bound to the top level.
// Depends on spm_pkg and stream_pattern_matcher_top.
module spm_checker #(
	parameter int OFFSET_BITS = 40
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic [spm_pkg::REQ_BITS-1:0]     req_type,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [OFFSET_BITS-1:0]           match_offset
);
	import spm_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(match_offset))
		else $error("result offset changed while stalled");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && req_ready && (req_type == REQ_STREAM), 2))
		else $error("result without a stream byte transfer two cycles earlier");

	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready || !res_valid |-> req_ready)
		else $error("input stalled while result side can drain");

endmodule

bind stream_pattern_matcher_top spm_checker #(
	.OFFSET_BITS(OFFSET_BITS)
) u_spm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.match_offset(res.match_offset)
);
